FILE: rtl/rat_acc_pkg.sv
// Package for the rational accumulator ALU.
// Holds the mode and status codes and the sequencer state type.
// No dependencies.
`timescale 1ns / 1ps

package rat_acc_pkg;

    // Operation codes on the mode field
    localparam logic [2:0] MODE_LOAD   = 3'd0;
    localparam logic [2:0] MODE_ADD    = 3'd1;
    localparam logic [2:0] MODE_SUB    = 3'd2;
    localparam logic [2:0] MODE_MUL    = 3'd3;
    localparam logic [2:0] MODE_DIV    = 3'd4;
    localparam logic [2:0] MODE_NEGATE = 3'd5;

    // Status codes on the result channel
    typedef enum logic [1:0] {
        STATUS_OK       = 2'd0,
        STATUS_ZERO_DEN = 2'd1,
        STATUS_OVERFLOW = 2'd2
    } status_t;

    // Sequencer states, one-hot
    typedef enum logic [6:0] {
        S_IDLE = 7'b0000001,
        S_MUL  = 7'b0000010,
        S_FORM = 7'b0000100,
        S_GCD  = 7'b0001000,
        S_DIV  = 7'b0010000,
        S_FIN  = 7'b0100000,
        S_OUT  = 7'b1000000
    } state_t;

endpackage

FILE: rtl/rational_accumulator_alu.sv
// Rational accumulator ALU: fraction accumulator with gcd reduction.
// Steps: products on one shared multiplier (none for load and negate), S_FORM forms
// the raw fraction, a binary gcd finds the common factor, and one shared restoring
// divider divides numerator, then denominator, by its odd part; S_FIN checks the range.
// One item at a time: s_ready is high only while idle, until the result is taken.
// Reset (synchronous, active low) sets the accumulator to 0/1 and idles the block.
`timescale 1ns / 1ps

module rational_accumulator_alu #(
    parameter int VALUE_WIDTH = 32
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    s_valid,
    output logic                    s_ready,
    input  logic [2:0]              s_mode,
    input  logic signed [31:0]      s_operand_numerator,
    input  logic signed [31:0]      s_operand_denominator,
    output logic                    m_valid,
    input  logic                    m_ready,
    output logic signed [31:0]      m_result_numerator,
    output logic signed [31:0]      m_result_denominator,
    output rat_acc_pkg::status_t    m_status
);
    import rat_acc_pkg::*;

    localparam int W     = VALUE_WIDTH;
    localparam int PW    = 2 * W;
    localparam int MW    = 2 * W + 1;
    localparam int CNT_W = $clog2(MW);
    localparam logic [MW-1:0]    HALF     = MW'(1) << (W - 1);
    localparam logic [CNT_W-1:0] DIV_LAST = CNT_W'(MW - 1);

    state_t state_reg;

    logic signed [W-1:0] acc_num_reg, acc_den_reg;
    status_t             status_reg;
    logic                m_valid_reg;

    // latched item, sign-magnitude
    logic [2:0]   mode_reg;
    logic [W-1:0] an_reg, ad_reg, on_reg, od_reg;
    logic         asn_reg, asd_reg, osn_reg, osd_reg;

    logic [1:0]    step_reg;
    logic [PW-1:0] prod0_reg, prod1_reg, prod2_reg;

    logic [MW-1:0] n_reg, d_reg, a_reg, b_reg, dv_reg, xq_reg, rem_reg;
    logic          sn_reg, sd_reg, phase_reg;
    logic [CNT_W-1:0] cnt_reg;

    // input split
    logic signed [W-1:0] in_num, in_den, acc_n, acc_d;
    assign in_num = s_operand_numerator[W-1:0];
    assign in_den = s_operand_denominator[W-1:0];
    assign acc_n  = acc_num_reg;
    assign acc_d  = acc_den_reg;

    // shared multiplier operand selection
    logic [W-1:0]  mul_x, mul_y;
    logic [PW-1:0] mul_p;
    logic          mul_last;

    always_comb begin
        mul_x = an_reg;
        mul_y = od_reg;
        case (step_reg)
            2'd0: begin
                mul_x = an_reg;
                mul_y = (mode_reg == MODE_MUL) ? on_reg : od_reg;
            end
            2'd1: begin
                mul_x = ad_reg;
                mul_y = (mode_reg == MODE_MUL) ? od_reg :
                        (mode_reg == MODE_DIV) ? on_reg : on_reg;
            end
            default: begin
                mul_x = ad_reg;
                mul_y = od_reg;
            end
        endcase
    end
    assign mul_p    = PW'(mul_x) * PW'(mul_y);
    assign mul_last = (mode_reg == MODE_ADD || mode_reg == MODE_SUB) ?
                      (step_reg == 2'd2) : (step_reg == 2'd1);

    // raw fraction forming
    logic [MW-1:0] f_rn, f_rd, p0, p1;
    logic          f_rsn, f_rsd, s1, s2, f_nop;

    always_comb begin
        p0    = MW'(prod0_reg);
        p1    = MW'(prod1_reg);
        s1    = asn_reg ^ osd_reg;
        s2    = osn_reg ^ asd_reg ^ (mode_reg == MODE_SUB);
        f_rn  = '0;
        f_rd  = MW'(1);
        f_rsn = 1'b0;
        f_rsd = 1'b0;
        f_nop = 1'b0;
        case (mode_reg)
            MODE_LOAD: begin
                f_rn = MW'(on_reg); f_rsn = osn_reg;
                f_rd = MW'(od_reg); f_rsd = osd_reg;
            end
            MODE_ADD, MODE_SUB: begin
                if (s1 == s2) begin
                    f_rn = p0 + p1; f_rsn = s1;
                end else if (p0 >= p1) begin
                    f_rn = p0 - p1; f_rsn = s1;
                end else begin
                    f_rn = p1 - p0; f_rsn = s2;
                end
                f_rd = MW'(prod2_reg); f_rsd = asd_reg ^ osd_reg;
            end
            MODE_MUL: begin
                f_rn = p0; f_rsn = asn_reg ^ osn_reg;
                f_rd = p1; f_rsd = asd_reg ^ osd_reg;
            end
            MODE_DIV: begin
                f_rn = p0; f_rsn = asn_reg ^ osd_reg;
                f_rd = p1; f_rsd = asd_reg ^ osn_reg;
            end
            MODE_NEGATE: begin
                f_rn = MW'(an_reg); f_rsn = ~asn_reg;
                f_rd = MW'(ad_reg); f_rsd = asd_reg;
            end
            default: f_nop = 1'b1;
        endcase
    end

    // subtractor for the gcd, and the trial subtraction for the division
    logic [MW-1:0] g_diff;
    logic          a_ge_b;
    assign a_ge_b = (a_reg >= b_reg);
    assign g_diff = a_ge_b ? (a_reg - b_reg) : (b_reg - a_reg);

    logic [MW:0]   trial;
    logic          take;
    logic [MW-1:0] rem_next, xq_next;
    assign trial    = {rem_reg, xq_reg[MW-1]};
    assign take     = (trial >= {1'b0, dv_reg});
    assign rem_next = take ? MW'(trial - {1'b0, dv_reg}) : trial[MW-1:0];
    assign xq_next  = {xq_reg[MW-2:0], take};

    // range check and join
    logic          fin_sn, fin_ok;
    logic [MW-1:0] n_neg, d_neg;
    assign fin_sn = sn_reg & (n_reg != '0);
    assign fin_ok = (fin_sn ? (n_reg <= HALF) : (n_reg < HALF)) &&
                    (sd_reg ? (d_reg <= HALF) : (d_reg < HALF));
    assign n_neg  = fin_sn ? (~n_reg + MW'(1)) : n_reg;
    assign d_neg  = sd_reg ? (~d_reg + MW'(1)) : d_reg;

    // sequencer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            m_valid_reg <= 1'b0;
            acc_num_reg <= '0;
            acc_den_reg <= W'(1);
            status_reg  <= STATUS_OK;
        end else begin
            unique case (state_reg)
                S_IDLE: begin
                    if (s_valid) begin
                        mode_reg <= s_mode;
                        asn_reg  <= acc_n < 0;
                        asd_reg  <= acc_d < 0;
                        osn_reg  <= in_num < 0;
                        osd_reg  <= in_den < 0;
                        an_reg   <= (acc_n < 0) ? W'(-acc_n) : W'(acc_n);
                        ad_reg   <= (acc_d < 0) ? W'(-acc_d) : W'(acc_d);
                        on_reg   <= (in_num < 0) ? W'(-in_num) : W'(in_num);
                        od_reg   <= (in_den < 0) ? W'(-in_den) : W'(in_den);
                        step_reg <= 2'd0;
                        if (s_mode == MODE_ADD || s_mode == MODE_SUB ||
                            s_mode == MODE_MUL || s_mode == MODE_DIV) begin
                            state_reg <= S_MUL;
                        end else begin
                            state_reg <= S_FORM;
                        end
                    end
                end
                S_MUL: begin
                    case (step_reg)
                        2'd0:    prod0_reg <= mul_p;
                        2'd1:    prod1_reg <= mul_p;
                        default: prod2_reg <= mul_p;
                    endcase
                    step_reg <= step_reg + 2'd1;
                    if (mul_last) begin
                        state_reg <= S_FORM;
                    end
                end
                S_FORM: begin
                    n_reg  <= f_rn;
                    d_reg  <= f_rd;
                    a_reg  <= f_rn;
                    b_reg  <= f_rd;
                    sn_reg <= f_rsn;
                    sd_reg <= f_rsd;
                    if (f_nop) begin
                        status_reg  <= STATUS_OK;
                        m_valid_reg <= 1'b1;
                        state_reg   <= S_OUT;
                    end else if (f_rd == '0) begin
                        status_reg  <= STATUS_ZERO_DEN;
                        m_valid_reg <= 1'b1;
                        state_reg   <= S_OUT;
                    end else begin
                        state_reg <= S_GCD;
                    end
                end
                S_GCD: begin
                    if (a_reg == '0 || b_reg == '0) begin
                        // odd part of the gcd found; common twos already shifted out
                        dv_reg    <= (a_reg == '0) ? b_reg : a_reg;
                        xq_reg    <= n_reg;
                        rem_reg   <= '0;
                        cnt_reg   <= '0;
                        phase_reg <= 1'b0;
                        state_reg <= S_DIV;
                    end else if (!a_reg[0] && !b_reg[0]) begin
                        a_reg <= a_reg >> 1;
                        b_reg <= b_reg >> 1;
                        n_reg <= n_reg >> 1;
                        d_reg <= d_reg >> 1;
                    end else if (!a_reg[0]) begin
                        a_reg <= a_reg >> 1;
                    end else if (!b_reg[0]) begin
                        b_reg <= b_reg >> 1;
                    end else if (a_ge_b) begin
                        a_reg <= g_diff >> 1;
                    end else begin
                        b_reg <= g_diff >> 1;
                    end
                end
                S_DIV: begin
                    if (cnt_reg != DIV_LAST) begin
                        rem_reg <= rem_next;
                        xq_reg  <= xq_next;
                        cnt_reg <= cnt_reg + CNT_W'(1);
                    end else if (!phase_reg) begin
                        // numerator done, restart on the denominator
                        n_reg     <= xq_next;
                        xq_reg    <= d_reg;
                        rem_reg   <= '0;
                        cnt_reg   <= '0;
                        phase_reg <= 1'b1;
                    end else begin
                        d_reg     <= xq_next;
                        state_reg <= S_FIN;
                    end
                end
                S_FIN: begin
                    if (fin_ok) begin
                        acc_num_reg <= n_neg[W-1:0];
                        acc_den_reg <= d_neg[W-1:0];
                        status_reg  <= STATUS_OK;
                    end else begin
                        status_reg  <= STATUS_OVERFLOW;
                    end
                    m_valid_reg <= 1'b1;
                    state_reg   <= S_OUT;
                end
                S_OUT: begin
                    if (m_ready) begin
                        m_valid_reg <= 1'b0;
                        state_reg   <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    // drive the result channel from the accumulator
    assign s_ready              = (state_reg == S_IDLE);
    assign m_valid              = m_valid_reg;
    assign m_result_numerator   = 32'(acc_num_reg);
    assign m_result_denominator = 32'(acc_den_reg);
    assign m_status             = status_reg;

endmodule

FILE: tb/rational_accumulator_alu_tb.sv
// Testbench for the rational accumulator ALU: directed and random fraction operations.
// Holds a scoreboard class with its own fraction predictor; depends on rat_acc_pkg and the RTL.
`timescale 1ns / 1ps

module rational_accumulator_alu_tb;
    import rat_acc_pkg::*;

    // Expected accumulator after one step
    typedef struct {
        logic signed [31:0] num;
        logic signed [31:0] den;
        status_t            st;
    } frac_result_t;

    int mismatch_count = 0;

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("mismatch %0s: got %0d expected %0d at %0t", what, got, want, $realtime);
        mismatch_count++;
    endtask

    // Fraction accumulator predictor and queue of expected results
    class frac_scoreboard;
        longint            acc_num = 0;
        longint            acc_den = 1;
        frac_result_t      pending[$];
        int                checked = 0;
        int                errors_seen[3] = '{0, 0, 0};

        function automatic longint unsigned gcd64(longint unsigned a, longint unsigned b);
            longint unsigned t;
            while (b != 0) begin
                t = a % b;
                a = b;
                b = t;
            end
            return a;
        endfunction

        function automatic bit in_range(longint unsigned mag, bit neg);
            return neg ? (mag <= 64'h8000_0000) : (mag < 64'h8000_0000);
        endfunction

        // Work out the next accumulator for an accepted transfer
        function void note_input(logic [2:0] mode, logic signed [31:0] opn,
                                 logic signed [31:0] opd);
            longint unsigned an, ad, on, od, rn, rd, p, q, g;
            bit asn, asd, osn, osd, rsn, rsd, ps, qs;
            frac_result_t res;
            asn = acc_num < 0; an = asn ? -acc_num : acc_num;
            asd = acc_den < 0; ad = asd ? -acc_den : acc_den;
            osn = opn < 0; on = osn ? -longint'(opn) : longint'(opn);
            osd = opd < 0; od = osd ? -longint'(opd) : longint'(opd);
            rn = 0; rd = 1; rsn = 0; rsd = 0;
            res.st = STATUS_OK;
            if (mode <= MODE_NEGATE) begin
                case (mode)
                    MODE_LOAD: begin
                        rn = on; rsn = osn; rd = od; rsd = osd;
                    end
                    MODE_ADD, MODE_SUB: begin
                        p = an * od; ps = asn != osd;
                        q = on * ad; qs = (osn != asd) != (mode == MODE_SUB);
                        if (ps == qs) begin
                            rn = p + q; rsn = ps;
                        end else if (p >= q) begin
                            rn = p - q; rsn = ps;
                        end else begin
                            rn = q - p; rsn = qs;
                        end
                        rd = ad * od; rsd = asd != osd;
                    end
                    MODE_MUL: begin
                        rn = an * on; rsn = asn != osn; rd = ad * od; rsd = asd != osd;
                    end
                    MODE_DIV: begin
                        rn = an * od; rsn = asn != osd; rd = ad * on; rsd = asd != osn;
                    end
                    default: begin
                        rn = an; rsn = !asn; rd = ad; rsd = asd;
                    end
                endcase
                if (rd == 0) begin
                    res.st = STATUS_ZERO_DEN;
                end else begin
                    g = gcd64(rn, rd);
                    rn = rn / g;
                    rd = rd / g;
                    if (rn == 0) rsn = 0;
                    if (!in_range(rn, rsn) || !in_range(rd, rsd)) begin
                        res.st = STATUS_OVERFLOW;
                    end else begin
                        acc_num = rsn ? -longint'(rn) : longint'(rn);
                        acc_den = rsd ? -longint'(rd) : longint'(rd);
                    end
                end
            end
            res.num = acc_num[31:0];
            res.den = acc_den[31:0];
            errors_seen[res.st]++;
            pending.push_back(res);
        endfunction

        // Compare one result transfer with the oldest expectation
        task check_result(logic signed [31:0] num, logic signed [31:0] den,
                          status_t st);
            frac_result_t want;
            if (pending.size() == 0) begin
                report_mismatch("unexpected result", num, 0);
                return;
            end
            want = pending.pop_front();
            checked++;
            if (num !== want.num) report_mismatch("numerator", num, want.num);
            if (den !== want.den) report_mismatch("denominator", den, want.den);
            if (st !== want.st) report_mismatch("status", st, want.st);
        endtask
    endclass

    logic               aclk = 0;
    logic               aresetn = 0;
    logic               s_valid = 0;
    logic               s_ready;
    logic [2:0]         s_mode = '0;
    logic signed [31:0] s_operand_numerator = '0;
    logic signed [31:0] s_operand_denominator = '0;
    logic               m_valid;
    logic               m_ready = 0;
    logic signed [31:0] m_result_numerator;
    logic signed [31:0] m_result_denominator;
    status_t            m_status;

    frac_scoreboard sb = new();
    int  send_idle_pct = 0;
    int  recv_stall_pct = 0;
    int  hold_off_cycles = 0;
    bit  stim_done = 0;
    int  items_sent = 0;

    rational_accumulator_alu #(.VALUE_WIDTH(32)) i_dut (
        .aclk                 (aclk),
        .aresetn              (aresetn),
        .s_valid              (s_valid),
        .s_ready              (s_ready),
        .s_mode               (s_mode),
        .s_operand_numerator  (s_operand_numerator),
        .s_operand_denominator(s_operand_denominator),
        .m_valid              (m_valid),
        .m_ready              (m_ready),
        .m_result_numerator   (m_result_numerator),
        .m_result_denominator (m_result_denominator),
        .m_status             (m_status)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    // Offer one transfer and hold it until accepted; valid drops only while idling
    task automatic send_op(input logic [2:0] mode, input logic signed [31:0] opn,
                           input logic signed [31:0] opd);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 0;
            @(negedge aclk);
        end
        s_valid <= 1;
        s_mode <= mode;
        s_operand_numerator <= opn;
        s_operand_denominator <= opd;
        do @(posedge aclk); while (!s_ready);
        sb.note_input(mode, opn, opd);
        items_sent++;
        @(negedge aclk);
    endtask

    function automatic logic signed [31:0] rand_value();
        case ($urandom_range(5))
            0: return $urandom;
            1: return $signed($urandom_range(40)) - 20;
            2: return {$urandom_range(1) ? 2'b10 : 2'b01, 30'($urandom)};
            3: return $urandom_range(1) ? 32'sh8000_0000 : 32'sh7fff_ffff;
            default: return $signed($urandom_range(2000)) - 1000;
        endcase
    endfunction

    // Receiver: stall at random, or hold off for a fixed stretch
    always @(negedge aclk) begin
        if (hold_off_cycles > 0) begin
            hold_off_cycles <= hold_off_cycles - 1;
            m_ready <= 0;
        end else begin
            m_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            sb.check_result(m_result_numerator, m_result_denominator, m_status);
    end

    task automatic run_random(input int count);
        int r;
        logic [2:0] mode;
        repeat (count) begin
            r = $urandom_range(99);
            mode = (r < 4) ? 3'($urandom_range(7, 6)) : 3'($urandom_range(5));
            // Keep the accumulator small most of the time so that sums stay in range
            if (r >= 4 && r < 20) begin
                mode = MODE_LOAD;
                send_op(mode, $signed($urandom_range(200)) - 100,
                        $urandom_range(9) ? $signed($urandom_range(60)) - 30 : 0);
            end else if (r < 85) begin
                send_op(mode, $signed($urandom_range(400)) - 200,
                        $urandom_range(19) ? $signed($urandom_range(200)) - 100 : 0);
            end else begin
                send_op(mode, rand_value(), rand_value());
            end
        end
    endtask

    initial begin
        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1;

        // Directed: every operation, zero denominators, extremes, unused modes
        send_op(MODE_ADD, 3, 1);
        send_op(MODE_SUB, 1, 2);
        send_op(MODE_MUL, -4, 6);
        send_op(MODE_DIV, 5, -7);
        send_op(MODE_NEGATE, 123, 456);
        send_op(MODE_LOAD, 7, 0);
        send_op(MODE_DIV, 0, 3);
        send_op(MODE_MUL, 0, 5);
        send_op(MODE_LOAD, 0, -9);
        send_op(MODE_LOAD, 32'sh8000_0000, 1);
        send_op(MODE_NEGATE, 0, 0);
        send_op(MODE_LOAD, 32'sh7fff_ffff, 32'sh8000_0000);
        send_op(MODE_MUL, 32'sh7fff_ffff, 32'sh7fff_ffff);
        send_op(MODE_ADD, 32'sh7fff_ffff, 1);
        send_op(MODE_LOAD, 32'sh8000_0000, 32'sh8000_0000);
        send_op(MODE_LOAD, -1, 32'sh7fff_ffff);
        send_op(MODE_DIV, 32'sh8000_0000, 1);
        send_op(3'd6, 5, 5);
        send_op(3'd7, -1, -1);
        send_op(MODE_LOAD, 32'shffff_ffff, 32'shffff_ffff);
        send_op(MODE_SUB, 32'sh5555_5555, 32'shaaaa_aaaa);

        // Long receiver hold-off while the sender keeps offering
        hold_off_cycles = 2000;
        run_random(20);

        run_random(250);
        send_idle_pct = 74;
        run_random(250);
        send_idle_pct = 0;
        recv_stall_pct = 74;
        run_random(250);
        send_idle_pct = 32;
        recv_stall_pct = 32;
        run_random(250);
        s_valid <= 0;
        stim_done = 1;
    end

    initial begin
        wait (stim_done);
        while (sb.pending.size() != 0) @(posedge aclk);
        repeat (300) @(posedge aclk);
        $display("Checked %0d results from %0d transfers across all six modes and unused codes.",
                 sb.checked, items_sent);
        $display("Status counts: ok %0d, zero denominator %0d, overflow %0d.",
                 sb.errors_seen[0], sb.errors_seen[1], sb.errors_seen[2]);
        if (mismatch_count == 0 && sb.pending.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    // Watchdog against a hung handshake
    initial begin
        #20ms;
        $display("timeout with %0d results outstanding", sb.pending.size());
        $display("RESULT: ERROR");
        $finish;
    end

endmodule
